>>> rtl/core/pdfs_pkg.sv
`default_nettype none

package pdfs_pkg;

	localparam int GROUP_MAX       = 14;           // bytes in the largest packed group
	localparam int BYTE_W          = 8;
	localparam int STREAM_W        = GROUP_MAX * BYTE_W;
	localparam int PIX_MAX         = 8;            // pixels in the largest group
	localparam int PIX_W           = 14;           // widest pixel
	localparam int PIX_W_10        = 10;
	localparam int PIX_W_12        = 12;
	localparam int PIX_12_COUNT    = 4;
	localparam int CFG_W           = 14;           // widest config register
	localparam int DEF_QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		FMT_10 = 2'd0,
		FMT_12 = 2'd1,
		FMT_14 = 2'd2
	} fmt_t;

	typedef enum logic [1:0] {
		REG_PIXEL_FORMAT = 2'd0,
		REG_PEDESTAL     = 2'd1,
		REG_CLIP_LEVEL   = 2'd2
	} cfg_reg_t;

	localparam logic [1:0]       RST_PIXEL_FORMAT = FMT_12;
	localparam logic [CFG_W-1:0] RST_PEDESTAL     = 14'd0;
	localparam logic [CFG_W-1:0] RST_CLIP_LEVEL   = 14'd4095;

	typedef logic [3:0] pos_t;
	typedef logic [GROUP_MAX-1:0][BYTE_W-1:0] group_bytes_t;

	typedef struct packed {
		logic [BYTE_W-1:0] image_byte;
		logic [BYTE_W-1:0] dark_byte;
	} in_beat_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              group_end;
	} out_beat_t;

	// one complete group handed from the collector to the processing side
	typedef struct packed {
		logic [1:0]   fmt;
		group_bytes_t img;
		group_bytes_t drk;
	} group_t;

	// bytes per packed group; the unused code packs as 14-bit
	function automatic pos_t group_len(input logic [1:0] fmt);
		pos_t n;
		unique case (fmt)
			FMT_10:  n = 4'd10;
			FMT_12:  n = 4'd6;
			default: n = 4'd14;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/pdfs_front.sv
`default_nettype none

module pdfs_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         pixel_format,
	input  pdfs_pkg::in_beat_t in_data,
	input  logic               in_valid,
	output logic               in_ready,
	output pdfs_pkg::group_t   grp,
	output logic               grp_push,
	input  logic               grp_ready
);
	import pdfs_pkg::*;

	group_bytes_t img_q;
	group_bytes_t drk_q;
	pos_t         pos_q;
	logic         last;
	logic         accept;

	// group closes once the byte count reaches the current format's length
	assign last     = (pos_q >= group_len(pixel_format) - 4'd1);
	assign in_ready = grp_ready || !last;
	assign accept   = in_valid && in_ready;
	assign grp_push = accept && last;

	// closing byte goes straight into the pushed group
	always_comb begin
		grp.fmt = pixel_format;
		grp.img = img_q;
		grp.drk = drk_q;
		grp.img[pos_q] = in_data.image_byte;
		grp.drk[pos_q] = in_data.dark_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= last ? '0 : pos_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			img_q[pos_q] <= in_data.image_byte;
			drk_q[pos_q] <= in_data.dark_byte;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/pdfs_fifo.sv
`default_nettype none

module pdfs_fifo #(
	parameter int unsigned DEPTH = pdfs_pkg::DEF_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  pdfs_pkg::group_t push_data,
	input  logic             push,
	output logic             push_ready,
	output pdfs_pkg::group_t pop_data,
	output logic             pop_valid,
	input  logic             pop
);
	import pdfs_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	group_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/pdfs_back.sv
`default_nettype none

module pdfs_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [pdfs_pkg::CFG_W-1:0] pedestal,
	input  logic [pdfs_pkg::CFG_W-1:0] clip_level,
	input  pdfs_pkg::group_t           grp,
	input  logic                       grp_valid,
	output logic                       grp_pop,
	output pdfs_pkg::out_beat_t        out_data,
	output logic                       out_valid,
	input  logic                       out_ready
);
	import pdfs_pkg::*;

	logic [STREAM_W-1:0]              img_s;
	logic [STREAM_W-1:0]              drk_s;
	logic [STREAM_W-1:0]              res_s;
	logic [PIX_MAX-1:0][PIX_W-1:0]    img_px;
	logic [PIX_MAX-1:0][PIX_W-1:0]    drk_px;
	logic [PIX_MAX-1:0][PIX_W-1:0]    res_px;
	group_bytes_t                     res_bytes;
	group_bytes_t                     ser_q;
	pos_t                             left_q;
	logic                             load;
	logic                             beat;

	// zero pixel in either frame marks a dead pixel: pass 0
	function automatic logic [PIX_W-1:0] sub_clamp(
		input logic [PIX_W-1:0] img,
		input logic [PIX_W-1:0] drk,
		input logic [PIX_W-1:0] blk,
		input logic [PIX_W-1:0] wht
	);
		logic [PIX_W:0]   base;
		logic [PIX_W-1:0] r;
		if (img < drk) begin
			base = {1'b0, blk};
		end else begin
			base = {1'b0, img} - {1'b0, drk} + {1'b0, blk};
		end
		if (img == '0 || drk == '0) begin
			r = '0;
		end else if (base > {1'b0, wht}) begin
			r = wht;
		end else begin
			r = base[PIX_W-1:0];
		end
		return r;
	endfunction

	// byte-swapped 16-bit words -> big-endian bit stream
	always_comb begin
		for (int k = 0; k < GROUP_MAX; k++) begin
			img_s[STREAM_W-1-BYTE_W*k -: BYTE_W] = grp.img[k ^ 1];
			drk_s[STREAM_W-1-BYTE_W*k -: BYTE_W] = grp.drk[k ^ 1];
		end
	end

	// pixel lanes
	always_comb begin
		for (int p = 0; p < PIX_MAX; p++) begin
			unique case (grp.fmt)
				FMT_10: begin
					img_px[p] = PIX_W'(img_s[STREAM_W-1-PIX_W_10*p -: PIX_W_10]);
					drk_px[p] = PIX_W'(drk_s[STREAM_W-1-PIX_W_10*p -: PIX_W_10]);
				end
				FMT_12: begin
					img_px[p] = PIX_W'(img_s[STREAM_W-1-PIX_W_12*p -: PIX_W_12]);
					drk_px[p] = PIX_W'(drk_s[STREAM_W-1-PIX_W_12*p -: PIX_W_12]);
				end
				default: begin
					img_px[p] = img_s[STREAM_W-1-PIX_W*p -: PIX_W];
					drk_px[p] = drk_s[STREAM_W-1-PIX_W*p -: PIX_W];
				end
			endcase
			res_px[p] = sub_clamp(img_px[p], drk_px[p], pedestal, clip_level);
		end
	end

	// repack; an oversized result keeps its low bits only
	always_comb begin
		res_s = '0;
		unique case (grp.fmt)
			FMT_10: begin
				for (int p = 0; p < PIX_MAX; p++) begin
					res_s[STREAM_W-1-PIX_W_10*p -: PIX_W_10] = res_px[p][PIX_W_10-1:0];
				end
			end
			FMT_12: begin
				for (int p = 0; p < PIX_12_COUNT; p++) begin
					res_s[STREAM_W-1-PIX_W_12*p -: PIX_W_12] = res_px[p][PIX_W_12-1:0];
				end
			end
			default: begin
				for (int p = 0; p < PIX_MAX; p++) begin
					res_s[STREAM_W-1-PIX_W*p -: PIX_W] = res_px[p];
				end
			end
		endcase
		for (int k = 0; k < GROUP_MAX; k++) begin
			res_bytes[k] = res_s[STREAM_W-1-BYTE_W*(k ^ 1) -: BYTE_W];
		end
	end

	// byte serializer: reloads when empty or on the beat of a group's last byte
	assign out_valid          = (left_q != '0);
	assign out_data.out_byte  = ser_q[0];
	assign out_data.group_end = (left_q == 4'd1);
	assign beat               = out_valid && out_ready;
	assign load               = !out_valid || (beat && left_q == 4'd1);
	assign grp_pop            = load && grp_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (grp_pop) begin
			left_q <= group_len(grp.fmt);
		end else if (beat) begin
			left_q <= left_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (grp_pop) begin
			ser_q <= res_bytes;
		end else if (beat) begin
			for (int i = 0; i < GROUP_MAX - 1; i++) begin
				ser_q[i] <= ser_q[i + 1];
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/packed_raw_dark_frame_subtract.sv
`default_nettype none

// Dark-frame subtraction on packed raw data. Each input beat carries one byte
// of the image frame and the byte at the same offset of the dark frame. Bytes
// are gathered into groups of 10, 6 or 14 bytes (8 x 10-bit, 4 x 12-bit or
// 8 x 14-bit pixels, big-endian bit stream over byte-swapped 16-bit words).
// Every pixel pair becomes image - dark + pedestal, clamped to
// [pedestal, clip_level], or 0 when either pixel is 0; the group is
// repacked and sent out one byte per beat, group_end marking its last byte.
// Throughput is one input beat and one output beat per cycle, sustained while
// out_ready stays high: the input side only collects, a queue of QUEUE_DEPTH
// whole groups decouples it from the output side, and the output byte
// serializer reloads in the same cycle its last byte is taken. With the
// output side idle, a group is written to the queue, then to the serializer.
// Configuration (pixel_format, pedestal, clip_level at indexes 0..2) must only
// be written while no group is in flight; the unused format code packs as
// 14-bit, and a format change part way into a group closes it on the first
// beat that brings the byte count to or past the new length.

module packed_raw_dark_frame_subtract #(
	parameter int unsigned QUEUE_DEPTH = pdfs_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// config write port
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_idx,
	input  logic [pdfs_pkg::CFG_W-1:0] cfg_wdata,
	// byte-pair input
	input  pdfs_pkg::in_beat_t         in_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	// packed result output
	output pdfs_pkg::out_beat_t        out_data,
	output logic                       out_valid,
	input  logic                       out_ready
);
	import pdfs_pkg::*;

	logic [1:0]       pixel_format_q;
	logic [CFG_W-1:0] pedestal_q;
	logic [CFG_W-1:0] clip_level_q;

	group_t push_grp;
	group_t head_grp;
	logic   push;
	logic   push_ready;
	logic   head_valid;
	logic   pop;

	// Config registers: plain writes, no read-back. Out-of-range index ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q <= RST_PIXEL_FORMAT;
			pedestal_q     <= RST_PEDESTAL;
			clip_level_q   <= RST_CLIP_LEVEL;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_PIXEL_FORMAT: pixel_format_q <= cfg_wdata[1:0];
				REG_PEDESTAL:     pedestal_q     <= cfg_wdata;
				REG_CLIP_LEVEL:   clip_level_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Front: collects byte pairs, pushes a whole group on its closing beat.
	// Stalls only on a closing beat while the queue is full.
	pdfs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_format (pixel_format_q),
		.in_data      (in_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.grp          (push_grp),
		.grp_push     (push),
		.grp_ready    (push_ready)
	);

	// Group queue between collector and processing side.
	pdfs_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_grp),
		.push       (push),
		.push_ready (push_ready),
		.pop_data   (head_grp),
		.pop_valid  (head_valid),
		.pop        (pop)
	);

	// Back: eight subtract/clamp lanes on the queue head, repack, and the
	// registered byte serializer that drives the output.
	pdfs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pedestal   (pedestal_q),
		.clip_level (clip_level_q),
		.grp        (head_grp),
		.grp_valid  (head_valid),
		.grp_pop    (pop),
		.out_data   (out_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);

endmodule

`default_nettype wire

>>> rtl/core/pdfs_checker.sv
`default_nettype none

module pdfs_checker (
	input logic                       clk,
	input logic                       arst_n,
	input pdfs_pkg::in_beat_t         in_data,
	input logic                       in_valid,
	input logic                       in_ready,
	input pdfs_pkg::out_beat_t        out_data,
	input logic                       out_valid,
	input logic                       out_ready
);
	import pdfs_pkg::*;

	pos_t cnt_q;       // output beats seen in the current group
	logic out_beat;

	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (out_beat) begin
			cnt_q <= out_data.group_end ? '0 : cnt_q + 4'd1;
		end
	end

	// stalled input holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input changed while stalled");

	// stalled output holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	// a group is 6, 10 or 14 bytes long
	a_group_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && out_data.group_end |-> (cnt_q == 4'd5 || cnt_q == 4'd9 || cnt_q == 4'd13))
		else $error("group_end at wrong byte count");

	// never more than 14 bytes without group_end
	a_group_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.group_end |-> cnt_q < 4'd13)
		else $error("group overran 14 bytes");

endmodule

bind packed_raw_dark_frame_subtract pdfs_checker u_pdfs_checker (.*);

`default_nettype wire
